// File: hw/rtl/mrl_pkg.sv
// ----------------------------------------------------------------------------
// mrl_pkg
// Constant weights, biases and the piecewise-linear sigmoid of the color
// perceptron.
// ----------------------------------------------------------------------------
package mrl_pkg;

  localparam int OUT_UNITS = 3;
  localparam int ROM_UNITS = 13;
  localparam int WEIGHT_W  = 18;
  localparam int ARG_W     = 32;
  localparam int FRAC_W    = 16;

  // Converts a constant in units of 1e-4 to Q7.10, rounding ties away from zero.
  function automatic int qw(input int n);
    int r;
    if (n >= 0) begin
      r = (n * 1024 + 5000) / 10000;
    end else begin
      r = -((-n * 1024 + 5000) / 10000);
    end
    return r;
  endfunction

  function automatic int hid_w(input int u, input int k);
    int n;
    case (u * 3 + k)
      0: n = 24671;   1: n = -37772;  2: n = 6287;
      3: n = 8596;    4: n = 17352;   5: n = -18163;
      6: n = 4733;    7: n = -15772;  8: n = 3087;
      9: n = -2016;   10: n = 11063;  11: n = -4235;
      12: n = 5327;   13: n = 5717;   14: n = -15390;
      15: n = 8550;   16: n = -16208; 17: n = 8947;
      18: n = -5830;  19: n = -577;   20: n = 2519;
      21: n = -11034; 22: n = -39844; 23: n = -1268;
      24: n = -4751;  25: n = -3544;  26: n = 11623;
      27: n = -3358;  28: n = 5890;   29: n = 742;
      30: n = 3094;   31: n = -1850;  32: n = -2594;
      33: n = 4179;   34: n = -12258; 35: n = 5612;
      36: n = -38610; 37: n = -59788; 38: n = -25854;
      default: n = 0;
    endcase
    return qw(n);
  endfunction

  function automatic int hid_b(input int u);
    int n;
    case (u)
      0: n = -66803;  1: n = -49091;  2: n = -12176;  3: n = -15432;
      4: n = 14075;   5: n = -15569;  6: n = 3809;    7: n = 74756;
      8: n = -12459;  9: n = 15167;   10: n = -1532;  11: n = 13491;
      12: n = -113155;
      default: n = 0;
    endcase
    return qw(n);
  endfunction

  function automatic int out_w(input int o, input int u);
    int n;
    n = 0;
    if (u < ROM_UNITS) begin
      case (o * ROM_UNITS + u)
        0: n = -2056;    1: n = -11825;   2: n = -37045;   3: n = 46858;
        4: n = 32195;    5: n = 12343;    6: n = -40729;   7: n = -104762;
        8: n = 57097;    9: n = -120603;  10: n = -60346;  11: n = 1088;
        12: n = -17614;
        13: n = 13014;   14: n = 1538;    15: n = 129982;  16: n = -308843;
        17: n = 19304;   18: n = -52426;  19: n = -172415; 20: n = -2167;
        21: n = 62688;   22: n = 272889;  23: n = -22485;  24: n = -200248;
        25: n = -1025;
        26: n = -12749;  27: n = 56982;   28: n = -47196;  29: n = -65988;
        30: n = -158069; 31: n = -13181;  32: n = -64218;  33: n = 690;
        34: n = -269648; 35: n = -362279; 36: n = -352607; 37: n = -54404;
        38: n = -642;
        default: n = 0;
      endcase
    end
    return qw(n);
  endfunction

  function automatic int out_b(input int o);
    int n;
    case (o)
      0: n = 214799;
      1: n = 53802;
      2: n = 752749;
      default: n = 0;
    endcase
    return qw(n);
  endfunction

  // Piecewise-linear logistic function: argument Q10, result Q0.16.
  function automatic logic [FRAC_W-1:0] sigmoid_q16(input logic signed [ARG_W-1:0] x);
    logic [ARG_W-1:0] a;
    logic [FRAC_W:0]  y;
    logic [FRAC_W-1:0] r;
    a = x[ARG_W-1] ? ARG_W'(-x) : ARG_W'(x);
    if (a >= ARG_W'(5120)) begin
      y = 17'd65536;
    end else if (a >= ARG_W'(2432)) begin
      y = 17'(a << 1) + 17'd55296;
    end else if (a >= ARG_W'(1024)) begin
      y = 17'(a << 3) + 17'd40960;
    end else begin
      y = 17'(a << 4) + 17'd32768;
    end
    if (!x[ARG_W-1]) begin
      r = y[FRAC_W] ? 16'hFFFF : y[FRAC_W-1:0];
    end else begin
      r = 16'(17'd65536 - y);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mrl_cell.sv
// ----------------------------------------------------------------------------
// mrl_cell
// One hidden neuron: computes its sigmoid output, then adds its share to the
// three output sums, passing the color word and the sums to the next cell.
// ----------------------------------------------------------------------------
module mrl_cell #(
  parameter int IDX   = 0,
  parameter int FRAC  = 8,
  parameter int ACC_W = 40
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    v_in,
  input  logic [FRAC:0]           x_in  [3],
  input  logic signed [ACC_W-1:0] acc_in [3],
  output logic                    v_out,
  output logic [FRAC:0]           x_out [3],
  output logic signed [ACC_W-1:0] acc_out [3]
);
  import mrl_pkg::*;

  localparam int HS_W = FRAC + 28;
  localparam logic signed [WEIGHT_W-1:0] WH0 = WEIGHT_W'(hid_w(IDX, 0));
  localparam logic signed [WEIGHT_W-1:0] WH1 = WEIGHT_W'(hid_w(IDX, 1));
  localparam logic signed [WEIGHT_W-1:0] WH2 = WEIGHT_W'(hid_w(IDX, 2));
  localparam logic signed [WEIGHT_W-1:0] BH  = WEIGHT_W'(hid_b(IDX));
  localparam logic signed [WEIGHT_W-1:0] WO0 = WEIGHT_W'(out_w(0, IDX));
  localparam logic signed [WEIGHT_W-1:0] WO1 = WEIGHT_W'(out_w(1, IDX));
  localparam logic signed [WEIGHT_W-1:0] WO2 = WEIGHT_W'(out_w(2, IDX));

  logic                    v1;
  logic [FRAC:0]           x1 [3];
  logic signed [ACC_W-1:0] acc1 [3];
  logic [FRAC_W-1:0]       hid;
  logic signed [HS_W-1:0]  hsum;
  logic signed [HS_W-1:0]  harg;

  always_comb begin
    hsum = (HS_W'(BH) <<< FRAC)
         + HS_W'(WH0 * $signed({1'b0, x_in[0]}))
         + HS_W'(WH1 * $signed({1'b0, x_in[1]}))
         + HS_W'(WH2 * $signed({1'b0, x_in[2]}));
    harg = (hsum + (HS_W'(1) <<< (FRAC - 1))) >>> FRAC;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v_out <= 1'b0;
    end else begin
      v1    <= v_in;
      v_out <= v1;
    end
    x1      <= x_in;
    acc1    <= acc_in;
    hid     <= sigmoid_q16(ARG_W'(harg));
    x_out   <= x1;
    acc_out[0] <= acc1[0] + ACC_W'(WO0 * $signed({1'b0, hid}));
    acc_out[1] <= acc1[1] + ACC_W'(WO1 * $signed({1'b0, hid}));
    acc_out[2] <= acc1[2] + ACC_W'(WO2 * $signed({1'b0, hid}));
  end

  a_valid_delay: assert property (@(posedge clk) disable iff (rst)
    v_out |-> $past(v_in, 2))
    else $error("cell word appeared without an entering word");
  a_valid_pass: assert property (@(posedge clk) disable iff (rst)
    $past(v_in, 2) && !$past(rst, 1) && !$past(rst, 2) |-> v_out)
    else $error("cell dropped a word");

endmodule

// File: hw/rtl/mlp_rgb_to_lab_3_13_3.sv
// ----------------------------------------------------------------------------
// mlp_rgb_to_lab_3_13_3
// Two-layer perceptron mapping a color (red, green, blue) to three sigmoid
// outputs, built as a chain of hidden-neuron cells.
// ----------------------------------------------------------------------------
// A word is taken at each rising edge with start high and busy low; busy is
// always low, so one color may enter in every cycle.
// Each hidden neuron is one cell of the chain: it first registers the sigmoid
// of its weighted sum, then adds its share to the three output sums.
// The result appears after the whole cell chain and a final output register,
// marked by valid high for exactly one cycle; the output register
// applies the output sigmoid. Throughput is one color per cycle.
// The receiver cannot stall; results are shown once and not held.
// A synchronous reset empties the chain; words in flight are dropped.
// ----------------------------------------------------------------------------
module mlp_rgb_to_lab_3_13_3 #(
  parameter int HIDDEN_UNITS    = 13,
  parameter int INPUT_FRAC_BITS = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [INPUT_FRAC_BITS:0]   red,
  input  logic [INPUT_FRAC_BITS:0]   green,
  input  logic [INPUT_FRAC_BITS:0]   blue,
  output logic                       valid,
  output logic [mrl_pkg::FRAC_W-1:0] out_lightness,
  output logic [mrl_pkg::FRAC_W-1:0] out_green_red,
  output logic [mrl_pkg::FRAC_W-1:0] out_blue_yellow
);
  import mrl_pkg::*;

  localparam int ACC_W = 38 + $clog2(HIDDEN_UNITS + 1);
  localparam int LAT   = 2 * HIDDEN_UNITS + 1;
  localparam logic signed [WEIGHT_W-1:0] BO0 = WEIGHT_W'(out_b(0));
  localparam logic signed [WEIGHT_W-1:0] BO1 = WEIGHT_W'(out_b(1));
  localparam logic signed [WEIGHT_W-1:0] BO2 = WEIGHT_W'(out_b(2));

  logic                    v_c   [HIDDEN_UNITS+1];
  logic [INPUT_FRAC_BITS:0] x_c  [HIDDEN_UNITS+1][3];
  logic signed [ACC_W-1:0] acc_c [HIDDEN_UNITS+1][3];
  logic signed [ACC_W-1:0] oarg  [3];

  assign busy        = 1'b0;
  assign v_c[0]      = start && !busy;
  assign x_c[0][0]   = red;
  assign x_c[0][1]   = green;
  assign x_c[0][2]   = blue;
  assign acc_c[0][0] = ACC_W'(BO0) <<< FRAC_W;
  assign acc_c[0][1] = ACC_W'(BO1) <<< FRAC_W;
  assign acc_c[0][2] = ACC_W'(BO2) <<< FRAC_W;

  for (genvar i = 0; i < HIDDEN_UNITS; i++) begin : g_cell
    mrl_cell #(
      .IDX  (i),
      .FRAC (INPUT_FRAC_BITS),
      .ACC_W(ACC_W)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .v_in   (v_c[i]),
      .x_in   (x_c[i]),
      .acc_in (acc_c[i]),
      .v_out  (v_c[i+1]),
      .x_out  (x_c[i+1]),
      .acc_out(acc_c[i+1])
    );
  end

  always_comb begin
    for (int k = 0; k < OUT_UNITS; k++) begin
      oarg[k] = (acc_c[HIDDEN_UNITS][k] + (ACC_W'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= v_c[HIDDEN_UNITS];
    end
    out_lightness   <= sigmoid_q16(ARG_W'(oarg[0]));
    out_green_red   <= sigmoid_q16(ARG_W'(oarg[1]));
    out_blue_yellow <= sigmoid_q16(ARG_W'(oarg[2]));
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(start, LAT))
    else $error("result word without a matching start");
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_chain_end: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(v_c[HIDDEN_UNITS], 1))
    else $error("result word not fed by the cell chain");

endmodule
